// ----- design/sampled_curve_band_clipper_defines.svh -----
// assertion macros for the sampled curve band clipper
`ifndef SAMPLED_CURVE_BAND_CLIPPER_DEFINES_SVH
`define SAMPLED_CURVE_BAND_CLIPPER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCBC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scbc check failed");

// next-cycle implication, checked out of reset
`define SCBC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scbc check failed");

`endif

// ----- design/scbc_pkg.sv -----
// shared types and constants of the sampled curve band clipper
`default_nettype none
package scbc_pkg;

  localparam int Y_W     = 32;
  localparam int IDX_W   = 17;
  localparam int VNUM_W  = 18;
  localparam int NORM_W  = 16;
  localparam int RANGE_W = 31;
  localparam int NUM_W   = 60;
  localparam int DEN_W   = 36;
  localparam int QUO_W   = 25;
  localparam int FRAC_W  = 24;

  localparam logic [IDX_W-1:0]   MAX_SAMPLES        = IDX_W'(65536);
  localparam logic [RANGE_W-1:0] PLOT_RANGE_RESET   = RANGE_W'(655360);
  localparam logic [IDX_W-1:0]   SAMPLE_COUNT_RESET = IDX_W'(1024);
  localparam logic [QUO_W-1:0]   T_ONE              = QUO_W'(1) << FRAC_W;
  localparam logic signed [NORM_W-1:0] NORM_POS     = 16'sd16384;
  localparam logic signed [NORM_W-1:0] NORM_NEG     = -16'sd16384;

  localparam logic REG_PLOT_RANGE   = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  localparam logic KIND_VERTEX  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [1:0] {
    JOB_RESTART = 2'd0,
    JOB_SAMPLE  = 2'd1,
    JOB_CROSS   = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t               kind;
    logic                    pos;
    logic [VNUM_W-1:0]       vnum;
    logic                    is_final;
    logic                    is_last;
    logic [IDX_W-1:0]        xi;
    logic signed [Y_W-1:0]   y;
    logic signed [Y_W-1:0]   yp;
  } job_t;

  typedef struct packed {
    logic                     item_kind;
    logic [VNUM_W-1:0]        vertex_number;
    logic signed [NORM_W-1:0] x_norm;
    logic signed [NORM_W-1:0] y_norm;
    logic                     curve_done;
    logic                     last_of_run;
  } result_t;

endpackage
`default_nettype wire

// ----- design/scbc_div.sv -----
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module scbc_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [scbc_pkg::NUM_W-1:0] num,
  input  wire logic [scbc_pkg::DEN_W-1:0] den,
  output logic                            done,
  output logic [scbc_pkg::QUO_W-1:0]      quo
);
  import scbc_pkg::*;

  logic              busy;
  logic [4:0]        cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [DEN_W:0]    shifted;
  logic              ge;

  assign shifted = {rem, quo[QUO_W-1]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DEN_W'(num[NUM_W-1:QUO_W]);
      quo <= num[QUO_W-1:0];
      dsr <= den;
    end else if (busy) begin
      rem <= ge ? DEN_W'(shifted - {1'b0, dsr}) : shifted[DEN_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// ----- design/scbc_front.sv -----
// front end: sample numbering, band test and job list per sample
`default_nettype none
module scbc_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [scbc_pkg::Y_W-1:0] sample_y,
  input  wire logic                         sample_finite,
  input  wire logic [scbc_pkg::RANGE_W-1:0] r_eff,
  input  wire logic [scbc_pkg::IDX_W-1:0]   n_eff,
  input  wire logic                         jq_full,
  output logic                              job_push,
  output scbc_pkg::job_t                    job_data
);
  import scbc_pkg::*;

  logic [IDX_W-1:0]      sample_index;
  logic signed [Y_W-1:0] previous_y;
  logic                  previous_finite;
  logic                  previous_in_band;
  logic [VNUM_W-1:0]     vertex_counter;
  job_t                  pend [3];
  logic [1:0]            pend_cnt;
  logic [1:0]            pend_idx;

  logic                  accept;
  logic                  is_final;
  logic [IDX_W-1:0]      i_cur;
  logic [IDX_W-1:0]      i_prev;
  logic [Y_W:0]          y_ext;
  logic [Y_W:0]          y_abs;
  logic                  cur_in;
  logic                  y_pos, y_neg, yp_pos, yp_neg;
  job_t                  base;
  job_t                  jl [3];
  logic [1:0]            k;
  logic [1:0]            nv;

  assign accept   = push && !full;
  assign full     = pend_cnt != 2'd0;
  assign job_push = full && !jq_full;
  assign job_data = pend[pend_idx];

  always_comb begin
    is_final = sample_index >= n_eff;
    i_cur    = is_final ? n_eff : sample_index;
    i_prev   = (i_cur == '0) ? '0 : i_cur - IDX_W'(1);
    y_ext    = {sample_y[Y_W-1], sample_y};
    y_abs    = y_ext[Y_W] ? (Y_W+1)'(0) - y_ext : y_ext;
    cur_in   = {y_abs, 1'b0} <= (Y_W+2)'(r_eff);
    y_pos    = !sample_y[Y_W-1] && sample_y != '0;
    y_neg    = sample_y[Y_W-1];
    yp_pos   = !previous_y[Y_W-1] && previous_y != '0;
    yp_neg   = previous_y[Y_W-1];

    base          = '0;
    base.is_final = is_final;
    base.y        = sample_y;
    base.yp       = previous_y;
    for (int j = 0; j < 3; j++) jl[j] = base;
    k  = 2'd0;
    nv = 2'd0;

    if (!sample_finite) begin
      if (previous_in_band) begin
        jl[0].kind = JOB_RESTART;
        k = 2'd1;
      end
    end else if (previous_finite && previous_in_band != cur_in) begin
      jl[0].kind = JOB_CROSS;
      jl[0].pos  = cur_in ? yp_pos : y_pos;
      jl[0].xi   = i_prev;
      jl[0].vnum = vertex_counter;
      if (cur_in) begin
        jl[1].kind = JOB_SAMPLE;
        jl[1].xi   = i_cur;
        jl[1].vnum = vertex_counter + VNUM_W'(1);
        nv = 2'd2;
      end else begin
        jl[1].kind = JOB_RESTART;
        nv = 2'd1;
      end
      k = 2'd2;
    end else if (previous_finite && !previous_in_band && !cur_in &&
                 ((yp_pos && y_neg) || (yp_neg && y_pos))) begin
      jl[0].kind = JOB_CROSS;
      jl[0].pos  = yp_pos;
      jl[0].xi   = i_prev;
      jl[0].vnum = vertex_counter;
      jl[1].kind = JOB_CROSS;
      jl[1].pos  = y_pos;
      jl[1].xi   = i_prev;
      jl[1].vnum = vertex_counter + VNUM_W'(1);
      jl[2].kind = JOB_RESTART;
      k  = 2'd3;
      nv = 2'd2;
    end else if (cur_in) begin
      jl[0].kind = JOB_SAMPLE;
      jl[0].xi   = i_cur;
      jl[0].vnum = vertex_counter;
      k  = 2'd1;
      nv = 2'd1;
    end

    for (int j = 0; j < 3; j++) jl[j].is_last = (j == int'(k) - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index     <= '0;
      previous_y       <= '0;
      previous_finite  <= 1'b0;
      previous_in_band <= 1'b0;
      vertex_counter   <= '0;
      pend_cnt         <= '0;
      pend_idx         <= '0;
    end else if (accept) begin
      pend_cnt <= k;
      pend_idx <= '0;
      if (is_final) begin
        sample_index     <= '0;
        previous_y       <= '0;
        previous_finite  <= 1'b0;
        previous_in_band <= 1'b0;
        vertex_counter   <= '0;
      end else begin
        sample_index     <= i_cur + IDX_W'(1);
        vertex_counter   <= vertex_counter + VNUM_W'(nv);
        previous_finite  <= sample_finite;
        previous_in_band <= sample_finite && cur_in;
        if (sample_finite) previous_y <= sample_y;
      end
    end else if (job_push) begin
      pend_cnt <= pend_cnt - 2'd1;
      pend_idx <= pend_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < 3; j++) pend[j] <= jl[j];
    end
  end
endmodule
`default_nettype wire

// ----- design/scbc_jobq.sv -----
// four-deep job queue between front and back
`default_nettype none
module scbc_jobq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire scbc_pkg::job_t wr_data,
  output logic                q_full,
  input  wire logic           rd,
  output scbc_pkg::job_t      rd_data,
  output logic                q_empty
);
  import scbc_pkg::*;

  job_t       mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign q_full  = cnt == 3'd4;
  assign q_empty = cnt == 3'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end
endmodule
`default_nettype wire

// ----- design/scbc_back.sv -----
// back end: interpolation and normalisation through a shared divider, result queue
`default_nettype none
module scbc_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire scbc_pkg::job_t               job,
  input  wire logic                         job_valid,
  output logic                              job_pop,
  input  wire logic [scbc_pkg::RANGE_W-1:0] r_eff,
  input  wire logic [scbc_pkg::IDX_W-1:0]   n_eff,
  input  wire logic                         pop,
  output logic                              empty,
  output scbc_pkg::result_t                 head
);
  import scbc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_T_RUN = 7'b0000100,
    ST_X_GO  = 7'b0001000,
    ST_X_RUN = 7'b0010000,
    ST_Y_RUN = 7'b0100000,
    ST_WRITE = 7'b1000000
  } back_state_t;

  back_state_t              state;
  job_t                     cur;
  logic [QUO_W-1:0]         t_val;
  logic signed [NORM_W-1:0] x_res, y_res;

  result_t                  ofifo [4];
  logic [1:0]               owp, orp;
  logic [2:0]               ocnt;
  logic                     ofull, opush, opop;
  result_t                  res;

  logic                     div_start, div_done;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [QUO_W-1:0]         div_q;

  logic signed [IDX_W+1:0]  s;
  logic [IDX_W+1:0]         s_abs;
  logic signed [43:0]       a;
  logic [43:0]              a_abs;
  logic [Y_W:0]             y_ext, y_abs;
  logic signed [DEN_W-1:0]  edge_v, yp36, y36, tn, td;
  logic [DEN_W-1:0]         tn_abs, td_abs;
  logic                     t_special;
  logic [QUO_W-1:0]         t_fix;
  logic                     x_neg;
  logic [NUM_W-1:0]         x_num, y_num, t_num;
  logic [DEN_W-1:0]         x_den;
  logic [NORM_W-1:0]        q16;

  always_comb begin
    s      = $signed({1'b0, cur.xi, 1'b0}) - $signed({2'b00, n_eff});
    s_abs  = s[IDX_W+1] ? (IDX_W+2)'(0) - s : s;
    a      = $signed({s[IDX_W+1], s, 24'b0}) + $signed({18'b0, t_val, 1'b0});
    a_abs  = a[43] ? 44'd0 - a : a;
    y_ext  = {cur.y[Y_W-1], cur.y};
    y_abs  = y_ext[Y_W] ? (Y_W+1)'(0) - y_ext : y_ext;

    edge_v = cur.pos ? $signed(DEN_W'(r_eff)) : -$signed(DEN_W'(r_eff));
    yp36   = DEN_W'(cur.yp);
    y36    = DEN_W'(cur.y);
    tn     = edge_v - (yp36 <<< 1);
    td     = (y36 - yp36) <<< 1;
    tn_abs = tn[DEN_W-1] ? DEN_W'(0) - tn : tn;
    td_abs = td[DEN_W-1] ? DEN_W'(0) - td : td;

    t_special = 1'b1;
    t_fix     = '0;
    if (td == '0) begin
      t_fix = T_ONE;
    end else if (tn == '0 || (tn[DEN_W-1] != td[DEN_W-1])) begin
      t_fix = '0;
    end else if (tn_abs >= td_abs) begin
      t_fix = T_ONE;
    end else begin
      t_special = 1'b0;
    end

    t_num = NUM_W'({tn_abs[DEN_W-2:0], 24'b0}) + NUM_W'(td_abs >> 1);
    y_num = NUM_W'({y_abs, 15'b0}) + NUM_W'(r_eff >> 1);
    if (cur.kind == JOB_CROSS) begin
      x_num = NUM_W'(a_abs) + NUM_W'({n_eff, 9'b0});
      x_den = DEN_W'({n_eff, 10'b0});
      x_neg = a[43];
    end else begin
      x_num = NUM_W'({s_abs, 14'b0}) + NUM_W'(n_eff >> 1);
      x_den = DEN_W'(n_eff);
      x_neg = s[IDX_W+1];
    end

    unique case (state)
      ST_LOAD: begin
        div_num = t_num;
        div_den = td_abs;
      end
      ST_X_GO: begin
        div_num = x_num;
        div_den = x_den;
      end
      default: begin
        div_num = y_num;
        div_den = DEN_W'(r_eff);
      end
    endcase

    div_start = (state == ST_LOAD && cur.kind == JOB_CROSS && !t_special) ||
                (state == ST_X_GO) ||
                (state == ST_X_RUN && div_done && cur.kind == JOB_SAMPLE);
    q16 = div_q[NORM_W-1:0];
  end

  scbc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign job_pop = (state == ST_IDLE) && job_valid;
  assign opush   = (state == ST_WRITE) && !ofull;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (job_valid) state <= ST_LOAD;
        ST_LOAD: begin
          unique case (cur.kind)
            JOB_RESTART: state <= ST_WRITE;
            JOB_SAMPLE:  state <= ST_X_GO;
            JOB_CROSS:   state <= t_special ? ST_X_GO : ST_T_RUN;
            default:     state <= ST_IDLE;
          endcase
        end
        ST_T_RUN: if (div_done) state <= ST_X_GO;
        ST_X_GO:  state <= ST_X_RUN;
        ST_X_RUN: if (div_done) state <= (cur.kind == JOB_SAMPLE) ? ST_Y_RUN : ST_WRITE;
        ST_Y_RUN: if (div_done) state <= ST_WRITE;
        ST_WRITE: if (!ofull) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) cur <= job;
    if (state == ST_LOAD) begin
      t_val <= t_fix;
      x_res <= '0;
      y_res <= '0;
    end
    if (state == ST_T_RUN && div_done) t_val <= div_q;
    if (state == ST_X_RUN && div_done) begin
      x_res <= x_neg ? NORM_W'(0) - q16 : q16;
      y_res <= cur.pos ? NORM_POS : NORM_NEG;
    end
    if (state == ST_Y_RUN && div_done) begin
      y_res <= cur.y[Y_W-1] ? NORM_W'(0) - q16 : q16;
    end
  end

  // result queue
  always_comb begin
    res.item_kind     = (cur.kind == JOB_RESTART) ? KIND_RESTART : KIND_VERTEX;
    res.vertex_number = (cur.kind == JOB_RESTART) ? '0 : cur.vnum;
    res.x_norm        = x_res;
    res.y_norm        = y_res;
    res.curve_done    = cur.is_final;
    res.last_of_run   = cur.is_last;
  end

  assign ofull = ocnt == 3'd4;
  assign empty = ocnt == 3'd0;
  assign opop  = pop && !empty;
  assign head  = ofifo[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (opush) owp <= owp + 2'd1;
      if (opop)  orp <= orp + 2'd1;
      ocnt <= ocnt + 3'(opush) - 3'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) ofifo[owp] <= res;
  end
endmodule
`default_nettype wire

// ----- design/sampled_curve_band_clipper.sv -----
// top level of the sampled curve band clipper
//
//   channel  direction  handshake       beat
//   samples  in         push / full     sample_y, sample_finite
//   results  out        pop / empty     item_kind .. last_of_run
//   config   in         cfg_write       cfg_index, cfg_data
//
// a sample is taken when push is high and full is low; full stays high while its jobs
// (up to three) move into the four-deep job queue. a restart needs no divider run, a
// sample vertex runs it for x then y, a crossing for x alone when t saturates and for
// t then x otherwise; entering the band is a crossing and a vertex, a pass through it
// two crossings and a restart. the shared divider sets the rate. reset is synchronous.
`default_nettype none
module sampled_curve_band_clipper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic signed [scbc_pkg::Y_W-1:0] sample_y,
  input  wire logic                            sample_finite,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic                                 item_kind,
  output logic [scbc_pkg::VNUM_W-1:0]          vertex_number,
  output logic signed [scbc_pkg::NORM_W-1:0]   x_norm,
  output logic signed [scbc_pkg::NORM_W-1:0]   y_norm,
  output logic                                 curve_done,
  output logic                                 last_of_run,
  input  wire logic                            cfg_write,
  input  wire logic                            cfg_index,
  input  wire logic [scbc_pkg::RANGE_W-1:0]    cfg_data
);
  import scbc_pkg::*;
  `include "sampled_curve_band_clipper_defines.svh"

  logic [RANGE_W-1:0] plot_range;
  logic [IDX_W-1:0]   sample_count;
  logic [RANGE_W-1:0] r_eff;
  logic [IDX_W-1:0]   n_eff;

  logic    jq_full, jq_empty, jq_pop, job_push;
  job_t    job_data, jq_data;
  result_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      plot_range   <= PLOT_RANGE_RESET;
      sample_count <= SAMPLE_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PLOT_RANGE:   plot_range   <= cfg_data;
        REG_SAMPLE_COUNT: sample_count <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    r_eff = (plot_range == '0) ? RANGE_W'(1) : plot_range;
    if (sample_count == '0)            n_eff = IDX_W'(1);
    else if (sample_count > MAX_SAMPLES) n_eff = MAX_SAMPLES;
    else                               n_eff = sample_count;
  end

  scbc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample_y      (sample_y),
    .sample_finite (sample_finite),
    .r_eff         (r_eff),
    .n_eff         (n_eff),
    .jq_full       (jq_full),
    .job_push      (job_push),
    .job_data      (job_data)
  );

  scbc_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_data (job_data),
    .q_full  (jq_full),
    .rd      (jq_pop),
    .rd_data (jq_data),
    .q_empty (jq_empty)
  );

  scbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (jq_data),
    .job_valid (!jq_empty),
    .job_pop   (jq_pop),
    .r_eff     (r_eff),
    .n_eff     (n_eff),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  assign item_kind     = head.item_kind;
  assign vertex_number = head.vertex_number;
  assign x_norm        = head.x_norm;
  assign y_norm        = head.y_norm;
  assign curve_done    = head.curve_done;
  assign last_of_run   = head.last_of_run;

  `SCBC_ASSERT_IMP(a_restart_zero, !empty && item_kind == KIND_RESTART,
    vertex_number == '0 && x_norm == '0 && y_norm == '0)
  `SCBC_ASSERT_IMP(a_x_in_range, !empty && item_kind == KIND_VERTEX,
    x_norm >= NORM_NEG && x_norm <= NORM_POS)
  `SCBC_ASSERT_IMP(a_y_in_range, !empty && item_kind == KIND_VERTEX,
    y_norm >= NORM_NEG && y_norm <= NORM_POS)
  `SCBC_ASSERT_NXT(a_job_visible, job_push, !jq_empty)
endmodule
`default_nettype wire
